/* sv/float32_add_mul_div_unit_macros.svh */
// Assertion macros shared by the arithmetic unit.
`ifndef FLOAT32_ADD_MUL_DIV_UNIT_MACROS_SVH
`define FLOAT32_ADD_MUL_DIV_UNIT_MACROS_SVH

// Implication in the same cycle, masked while reset is asserted.
`define FMD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the next cycle, masked while reset is asserted.
`define FMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication into the next cycle that is also checked across reset.
`define FMD_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/fmd_pkg.sv */
`timescale 1ns / 1ps
package fmd_pkg;

    typedef enum logic [1:0] {
        ACT_ADD  = 2'd0,
        ACT_MUL  = 2'd1,
        ACT_DIV  = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    localparam logic [31:0] HIDDEN_BIT = 32'h0080_0000;
    localparam logic [31:0] FRAC_MASK  = 32'h007F_FFFF;
    localparam logic [31:0] SE_MASK    = 32'hFF80_0000;
    localparam logic [31:0] ONE_EXP    = 32'h3F80_0000;
    localparam logic [31:0] INF_BITS   = 32'h7F80_0000;
    localparam logic [31:0] ABS_MASK   = 32'h7FFF_FFFF;
    localparam logic [31:0] QUOT_MASK  = 32'h7FFF_FF00;

    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES         = 8;

endpackage

/* sv/float32_add_mul_div_unit.sv */
// An accepted input transaction moves through the stages r_vld[1] to r_vld[L] to the output.
// Throughput: one transaction per cycle; the eight-stage restoring divider sets the depth.
// All stages advance together unless the output holds a result that is stalled.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
module float32_add_mul_div_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result_bits
);
    import fmd_pkg::*;
    `include "float32_add_mul_div_unit_macros.svh"

    localparam int QL = DIV_STAGES + 1;
    localparam int L  = DIV_STAGES + 2;

    logic        r_vld [1:L];
    t_action     r_act [1:L];
    logic [31:0] r_a   [1:QL];
    logic [31:0] r_b   [1:QL];
    logic [24:0] r_rem [1:DIV_STAGES];
    logic [31:0] r_q   [1:QL];
    logic [31:0] r_amd [4:QL];
    logic [31:0] r_res;

    logic [24:0] w_rem [1:DIV_STAGES];
    logic [31:0] w_q   [1:DIV_STAGES];
    logic [31:0] w_am;
    logic [31:0] n_res;
    logic        w_en;

    assign w_en    = !(r_vld[L] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[L];
    assign o_result_bits = r_res;

    fmd_add_mul u_add_mul (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_action (t_action'(i_action)),
        .i_a      (i_operand_a),
        .i_b      (i_operand_b),
        .o_result (w_am)
    );

    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
        fmd_div_step u_step (
            .i_rem  (r_rem[k]),
            .i_quot (r_q[k]),
            .i_dvsr ({1'b1, r_b[k][22:0]}),
            .o_rem  (w_rem[k]),
            .o_quot (w_q[k])
        );
    end

    always_comb begin
        logic        low;
        logic [31:0] q2, r, a, b, dres;
        a    = r_a[QL];
        b    = r_b[QL];
        low  = ~r_q[QL][31];
        q2   = low ? {r_q[QL][30:0], 1'b0} : r_q[QL];
        r    = (((a & SE_MASK) - (b & SE_MASK) + ONE_EXP) - (low ? HIDDEN_BIT : 32'd0))
               | ((q2 & QUOT_MASK) >> 8);
        if ((a & ABS_MASK) == 32'd0) begin
            dres = a;
        end else if ((b & ABS_MASK) == 32'd0) begin
            dres = INF_BITS;
        end else if (r[31] ^ a[31] ^ b[31]) begin
            dres = INF_BITS;
        end else begin
            dres = r;
        end
        case (r_act[QL])
            ACT_ADD: n_res = r_amd[QL];
            ACT_MUL: n_res = r_amd[QL];
            ACT_DIV: n_res = dres;
            default: n_res = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= L; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[1] <= i_valid;
            for (int k = 2; k <= L; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_act[1] <= t_action'(i_action);
            r_a[1]   <= i_operand_a;
            r_b[1]   <= i_operand_b;
            r_rem[1] <= {2'b01, i_operand_a[22:0]};
            r_q[1]   <= 32'd0;
            for (int k = 2; k <= QL; k++) begin
                r_a[k]   <= r_a[k-1];
                r_b[k]   <= r_b[k-1];
                r_q[k]   <= w_q[k-1];
            end
            for (int k = 2; k <= DIV_STAGES; k++) begin
                r_rem[k] <= w_rem[k-1];
            end
            for (int k = 2; k <= L; k++) begin
                r_act[k] <= r_act[k-1];
            end
            r_amd[4] <= w_am;
            for (int k = 5; k <= QL; k++) begin
                r_amd[k] <= r_amd[k-1];
            end
            r_res <= n_res;
        end
    end

    `FMD_ASSERT_IMP(a_stall_needs_result, o_stall, o_valid, "input stalled without a pending result")
    `FMD_ASSERT_NEXT(a_advance_fills_output, r_vld[L-1] && !o_stall, o_valid, "transaction lost before the output stage")
    `FMD_ASSERT_IMP(a_unused_code_zero, o_valid && r_act[L] == ACT_NONE, o_result_bits == 32'd0, "unused operation gave a nonzero result")
    `FMD_ASSERT_NEXT_ALWAYS(a_reset_clears_output, !i_rst_n, !o_valid, "output valid right after reset")

endmodule

/* sv/fmd_div_step.sv */
`timescale 1ns / 1ps
module fmd_div_step (
    input  logic [24:0] i_rem,
    input  logic [31:0] i_quot,
    input  logic [23:0] i_dvsr,
    output logic [24:0] o_rem,
    output logic [31:0] o_quot
);
    import fmd_pkg::*;

    always_comb begin
        logic [24:0] rem;
        logic [31:0] quot;
        rem  = i_rem;
        quot = i_quot;
        for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
            quot = {quot[30:0], 1'b0};
            if (rem >= {1'b0, i_dvsr}) begin
                quot[0] = 1'b1;
                rem     = rem - {1'b0, i_dvsr};
            end
            rem = {rem[23:0], 1'b0};
        end
        o_rem  = rem;
        o_quot = quot;
    end

endmodule

/* sv/fmd_add_mul.sv */
`timescale 1ns / 1ps
module fmd_add_mul (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  fmd_pkg::t_action      i_action,
    input  logic [31:0]           i_a,
    input  logic [31:0]           i_b,
    output logic [31:0]           o_result
);
    import fmd_pkg::*;

    logic        r_sgn1, r_sub1;
    logic [7:0]  r_eb1;
    logic [23:0] r_mb1, r_ms1;
    logic [47:0] r_prod1;
    logic [31:0] r_a1, r_b1;
    t_action     r_act1;

    logic [24:0] r_sum2;
    logic [7:0]  r_eb2;
    logic        r_sgn2;
    logic [31:0] r_mul2;
    t_action     r_act2;

    logic [31:0] r_res3;

    logic        n_sgn1, n_sub1;
    logic [7:0]  n_eb1;
    logic [23:0] n_mb1, n_ms1;
    logic [24:0] n_sum2;
    logic [31:0] n_mul2;
    logic [31:0] n_res3;

    always_comb begin
        logic [31:0] big, small_op;
        logic [7:0]  es, diff;
        logic [4:0]  shamt;
        if ((i_a & ABS_MASK) < (i_b & ABS_MASK)) begin
            big      = i_b;
            small_op = i_a;
        end else begin
            big      = i_a;
            small_op = i_b;
        end
        n_eb1  = big[30:23];
        es     = small_op[30:23];
        diff   = n_eb1 - es;
        shamt  = (diff > 8'd24) ? 5'd24 : diff[4:0];
        n_mb1  = {1'b1, big[22:0]};
        n_ms1  = {1'b1, small_op[22:0]} >> shamt;
        n_sgn1 = big[31];
        n_sub1 = big[31] ^ small_op[31];
    end

    always_comb begin
        logic [24:0] acc;
        logic        hi;
        logic [23:0] accs;
        logic [31:0] se, r;
        n_sum2 = r_sub1 ? ({1'b0, r_mb1} - {1'b0, r_ms1})
                        : ({1'b0, r_mb1} + {1'b0, r_ms1});
        acc  = r_prod1[47:23];
        hi   = acc[24];
        accs = hi ? acc[24:1] : acc[23:0];
        se   = ((r_a1 & SE_MASK) - ONE_EXP + (r_b1 & SE_MASK)) & SE_MASK;
        r    = se + {8'd0, accs} - (hi ? 32'd0 : HIDDEN_BIT);
        if (r_a1 == 32'd0 || r_b1 == 32'd0) begin
            n_mul2 = 32'd0;
        end else if (r[31] ^ r_a1[31] ^ r_b1[31]) begin
            n_mul2 = INF_BITS;
        end else begin
            n_mul2 = r;
        end
    end

    always_comb begin
        logic [4:0]  lz;
        logic [4:0]  s;
        logic [24:0] mbn;
        logic [8:0]  e9;
        lz = 5'd25;
        for (int i = 0; i < 25; i++) begin
            if (r_sum2[i]) begin
                lz = 5'(24 - i);
            end
        end
        s = 5'd0;
        if (lz == 5'd0) begin
            mbn = r_sum2 >> 1;
            e9  = {1'b0, r_eb2} + 9'd1;
        end else if (lz == 5'd1) begin
            mbn = r_sum2;
            e9  = {1'b0, r_eb2};
        end else begin
            s   = lz - 5'd1;
            mbn = r_sum2 << s;
            e9  = {1'b0, r_eb2} - {4'd0, s};
        end
        if (r_act2 == ACT_ADD) begin
            n_res3 = {r_sgn2 | e9[8], e9[7:0], mbn[22:0]};
        end else begin
            n_res3 = r_mul2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sgn1  <= n_sgn1;
            r_sub1  <= n_sub1;
            r_eb1   <= n_eb1;
            r_mb1   <= n_mb1;
            r_ms1   <= n_ms1;
            r_prod1 <= {24'd0, 1'b1, i_a[22:0]} * {24'd0, 1'b1, i_b[22:0]};
            r_a1    <= i_a;
            r_b1    <= i_b;
            r_act1  <= i_action;
            r_sum2  <= n_sum2;
            r_eb2   <= r_eb1;
            r_sgn2  <= r_sgn1;
            r_mul2  <= n_mul2;
            r_act2  <= r_act1;
            r_res3  <= n_res3;
        end
    end

    assign o_result = r_res3;

endmodule
